[rtl/tensor_transpose_int8_macros.svh]
// assertion macros for the tensor transpose block
`ifndef TENSOR_TRANSPOSE_INT8_MACROS_SVH
`define TENSOR_TRANSPOSE_INT8_MACROS_SVH

// condition implies consequence in the same cycle
`define TTI8_ASSERT_SAME(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("tensor transpose check failed");

// condition implies consequence in the next cycle
`define TTI8_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("tensor transpose check failed");

`endif

[rtl/tti8_pkg.sv]
// shared types and constants of the tensor transpose block
package tti8_pkg;

    localparam int SLOTS      = 4;
    localparam int MAX_DIMS   = 4;
    localparam int SHAPE_W    = 13;
    localparam int DIM_W      = 3;
    localparam int PERM_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'((MAX_DIMS < SLOTS) ? MAX_DIMS : SLOTS);

    localparam logic [CFG_ADDR_W-1:0] REG_DIM_COUNT   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE_ZERO  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE_ONE   = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE_TWO   = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_SHAPE_THREE = CFG_ADDR_W'(4);
    localparam logic [CFG_ADDR_W-1:0] REG_PERM_CODE   = CFG_ADDR_W'(5);

    localparam logic [DIM_W-1:0]  DIM_COUNT_RST = DIM_W'(1);
    localparam logic [PERM_W-1:0] PERM_CODE_RST = PERM_W'(228);

    typedef logic [SHAPE_W-1:0] t_shape;

    typedef struct packed {
        logic       init;
        logic       stride;
        logic       step_mul;
        logic       step_acc;
        logic       finish;
        logic [1:0] idx;
        logic       push;
        logic       pull;
    } t_cmd;

    typedef struct packed {
        logic cfg_restart;
    } t_stat;

endpackage

[rtl/tensor_transpose_int8.sv]
// top level of the int8 tensor axis transpose block
// a pull item gives its result in the cycle after acceptance; one item per cycle while results are taken
// a push item gives no result
// after reset and after each write to register addresses 0 to 5 the stride and step setup runs,
// during which no item is accepted
// reset is synchronous and active low; registers return to one dimension, unit shapes, identity order
`include "tensor_transpose_int8_macros.svh"

module tensor_transpose_int8 #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tti8_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [tti8_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_action,
    input  logic signed [7:0]                i_in_value,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [7:0]                o_out_value,
    output logic                             o_is_last,
    output logic                             o_status
);
    import tti8_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tti8_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (w_stat),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    tti8_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_in_value  (i_in_value),
        .o_stat      (w_stat),
        .o_out_value (o_out_value),
        .o_is_last   (o_is_last),
        .o_status    (o_status)
    );

    // no item is taken while setup runs
    `TTI8_ASSERT_SAME(a_no_item_in_setup, i_clk, i_rst_n, !o_in_stall, !(w_cmd.init || w_cmd.stride || w_cmd.step_mul || w_cmd.step_acc || w_cmd.finish))
    // every accepted pull shows a result next cycle
    `TTI8_ASSERT_NEXT(a_pull_gives_item, i_clk, i_rst_n, w_cmd.pull, o_out_valid)
    // an error result is never marked last and carries zero
    `TTI8_ASSERT_SAME(a_err_result_clean, i_clk, i_rst_n, o_out_valid && o_status, !o_is_last && (o_out_value == 8'sd0))

endmodule

[rtl/tti8_ctrl.sv]
// controller: handshake, output valid and the setup sequencer
module tti8_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tti8_pkg::t_stat  i_stat,
    input  logic             i_in_valid,
    input  logic             i_action,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output tti8_pkg::t_cmd   o_cmd
);
    import tti8_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_STRIDE = 3'd1;
    localparam logic [2:0] ST_STEP   = 3'd2;
    localparam logic [2:0] ST_FIN    = 3'd3;
    localparam logic [2:0] ST_READY  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       w_free;
    logic       w_acc;

    assign w_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_READY) || i_stat.cfg_restart || !w_free;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.init     = (r_state == ST_INIT);
        o_cmd.stride   = (r_state == ST_STRIDE);
        o_cmd.step_mul = (r_state == ST_STEP) && !r_cnt[0];
        o_cmd.step_acc = (r_state == ST_STEP) && r_cnt[0];
        o_cmd.finish   = (r_state == ST_FIN);
        o_cmd.idx      = (r_state == ST_STEP) ? ~r_cnt[2:1] : ~r_cnt[1:0];
        o_cmd.push     = w_acc && !i_action;
        o_cmd.pull     = w_acc && i_action;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_INIT: begin
                n_state = ST_STRIDE;
                n_cnt   = '0;
            end
            ST_STRIDE: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_state = ST_STEP;
                    n_cnt   = '0;
                end
            end
            ST_STEP: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_READY;
            end
            ST_READY: begin
                n_state = ST_READY;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
        if (i_stat.cfg_restart) begin
            n_state = ST_INIT;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.pull) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/tti8_dp.sv]
// datapath: config registers, stride setup, element store and output odometer
module tti8_dp #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tti8_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [tti8_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  tti8_pkg::t_cmd                       i_cmd,
    input  logic signed [7:0]                    i_in_value,
    output tti8_pkg::t_stat                      o_stat,
    output logic signed [7:0]                    o_out_value,
    output logic                                 o_is_last,
    output logic                                 o_status
);
    import tti8_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int PW = CW + SHAPE_W;
    localparam int MW = SHAPE_W + AW;
    localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

    // configuration
    logic [DIM_W-1:0]  r_dim_count;
    t_shape            r_shape [SLOTS];
    logic [PERM_W-1:0] r_perm;

    // derived setup
    logic [CW-1:0] r_prod;
    logic          r_over;
    logic [AW-1:0] r_stride [SLOTS];
    logic [AW-1:0] r_step [SLOTS];
    logic [AW-1:0] r_acc;
    logic [AW-1:0] r_wb;
    t_shape        r_ext [SLOTS];
    logic          r_err;
    logic [CW-1:0] r_limit;

    // run state
    logic [AW-1:0] r_wi;
    t_shape        r_coord [SLOTS];
    logic [AW-1:0] r_addr;
    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd;
    logic          r_out_err;
    logic          r_out_last;

    logic [DIM_W-1:0] w_used;
    logic [1:0]       w_src [SLOTS];
    logic [SLOTS-1:0] w_seen;
    logic             w_perm_err;
    t_shape           w_ext [SLOTS];
    logic [AW-1:0]    w_ostride [SLOTS];
    logic [PW-1:0]    w_prod;
    logic [MW-1:0]    w_wb;
    logic             w_err;
    logic [SLOTS-1:0] w_at_max;
    logic             w_carry;
    logic [AW-1:0]    w_step_sel;
    t_shape           n_coord [SLOTS];
    logic [AW-1:0]    n_addr;
    logic [AW-1:0]    n_wi;

    assign o_stat.cfg_restart = i_cfg_we && (i_cfg_addr <= REG_PERM_CODE);

    always_comb begin
        if (r_dim_count == '0) begin
            w_used = DIM_W'(1);
        end else if (r_dim_count > DIM_LIMIT) begin
            w_used = DIM_LIMIT;
        end else begin
            w_used = r_dim_count;
        end
    end

    // permutation decode
    always_comb begin
        w_seen     = '0;
        w_perm_err = 1'b0;
        for (int d = 0; d < SLOTS; d++) begin
            w_src[d]     = r_perm[2*d +: 2];
            w_ext[d]     = SHAPE_W'(1);
            w_ostride[d] = '0;
            if (DIM_W'(d) < w_used) begin
                if ((DIM_W'(w_src[d]) >= w_used) || w_seen[w_src[d]]) begin
                    w_perm_err = 1'b1;
                end
                w_seen[w_src[d]] = 1'b1;
                w_ext[d]         = r_shape[w_src[d]];
                w_ostride[d]     = r_stride[w_src[d]];
            end
        end
    end

    assign w_prod = PW'(r_prod) * PW'(r_shape[i_cmd.idx]);
    assign w_wb   = MW'(w_ext[i_cmd.idx] - SHAPE_W'(1)) * MW'(w_ostride[i_cmd.idx]);
    assign w_err  = r_over || (r_prod == '0) || w_perm_err;

    // output odometer, last dimension fastest
    always_comb begin
        w_carry    = 1'b1;
        w_step_sel = '0;
        for (int d = SLOTS - 1; d >= 0; d--) begin
            w_at_max[d] = (r_coord[d] == (r_ext[d] - SHAPE_W'(1)));
            n_coord[d]  = r_coord[d];
            if (w_carry) begin
                if (w_at_max[d]) begin
                    n_coord[d] = '0;
                end else begin
                    n_coord[d] = r_coord[d] + SHAPE_W'(1);
                    w_step_sel = r_step[d];
                    w_carry    = 1'b0;
                end
            end
        end
        n_addr = w_carry ? '0 : (r_addr + w_step_sel);
    end

    assign n_wi = ((CW'(r_wi) + CW'(1)) >= r_limit) ? '0 : (r_wi + AW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIM_COUNT_RST;
            for (int d = 0; d < SLOTS; d++) begin
                r_shape[d] <= SHAPE_W'(1);
                r_coord[d] <= '0;
            end
            r_perm  <= PERM_CODE_RST;
            r_wi    <= '0;
            r_addr  <= '0;
            r_err   <= 1'b0;
            r_limit <= DEPTH_C;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_DIM_COUNT:   r_dim_count <= i_cfg_data[DIM_W-1:0];
                    REG_SHAPE_ZERO:  r_shape[0]  <= i_cfg_data;
                    REG_SHAPE_ONE:   r_shape[1]  <= i_cfg_data;
                    REG_SHAPE_TWO:   r_shape[2]  <= i_cfg_data;
                    REG_SHAPE_THREE: r_shape[3]  <= i_cfg_data;
                    REG_PERM_CODE:   r_perm      <= i_cfg_data[PERM_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.finish) begin
                r_err   <= w_err;
                r_limit <= w_err ? DEPTH_C : r_prod;
            end
            if (o_stat.cfg_restart) begin
                r_wi   <= '0;
                r_addr <= '0;
                for (int d = 0; d < SLOTS; d++) begin
                    r_coord[d] <= '0;
                end
            end else begin
                if (i_cmd.push) begin
                    r_wi <= n_wi;
                end
                if (i_cmd.pull && !r_err) begin
                    r_addr <= n_addr;
                    for (int d = 0; d < SLOTS; d++) begin
                        r_coord[d] <= n_coord[d];
                    end
                end
            end
        end
    end

    // stride and step setup, each through its own multiplier
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_prod <= CW'(1);
            r_over <= 1'b0;
            r_acc  <= '0;
        end
        if (i_cmd.stride) begin
            if (DIM_W'(i_cmd.idx) < w_used) begin
                r_stride[i_cmd.idx] <= r_prod[AW-1:0];
                r_prod              <= w_prod[CW-1:0];
                if (w_prod > DEPTH_P) begin
                    r_over <= 1'b1;
                end
            end else begin
                r_stride[i_cmd.idx] <= '0;
            end
        end
        if (i_cmd.step_mul) begin
            r_wb              <= w_wb[AW-1:0];
            r_step[i_cmd.idx] <= w_ostride[i_cmd.idx] - r_acc;
        end
        if (i_cmd.step_acc) begin
            r_acc <= r_acc + r_wb;
        end
        if (i_cmd.finish) begin
            for (int d = 0; d < SLOTS; d++) begin
                r_ext[d] <= w_ext[d];
            end
        end
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wi] <= i_in_value;
        end
        if (i_cmd.pull) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pull) begin
            r_out_err  <= r_err;
            r_out_last <= !r_err && (&w_at_max);
        end
    end

    assign o_out_value = r_out_err ? 8'sd0 : $signed(r_rd);
    assign o_is_last   = r_out_last;
    assign o_status    = r_out_err;

endmodule
